// ----- sv/tdq_pkg.sv -----
// ----------------------------------------------------------------------------
// tdq_pkg
// Shared widths, request kinds and address helpers of the tree distance engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tdq_pkg;

  localparam int unsigned MaxNodes  = 64;
  localparam int unsigned NodeW     = 6;
  localparam int unsigned CountW    = 7;
  localparam int unsigned EdgeW     = 16;
  localparam int unsigned DistW     = 22;
  localparam int unsigned CellW     = 2 * NodeW;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  // request kinds on tuser
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  typedef logic [NodeW-1:0]  node_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [CellW-1:0]  cell_t;

  // symmetric pair address: smaller node in the upper half
  function automatic cell_t pair_cell(node_t x, node_t y);
    cell_t c;
    c = (x < y) ? {x, y} : {y, x};
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/tree_distance_query_engine.sv -----
// A query's distance is read as its request is taken, then registered for output from S_QRD,
// where it waits while the output stalls; an edge load's mirrored write follows in S_LD2.
// Build: pairs are extended one at a time through one shared adder/saturator, each read
// from the distance memory in S_JRD and written in S_JWR.
// Requests are taken only in S_IDLE, after the last leaves S_LD2 or S_QRD; busy during a build.
// Reset: asynchronous, active low; afterwards S_CLEAR clears the edge-present memory row by row,
// during which no request is taken (configuration writes are taken).
// ----------------------------------------------------------------------------
// tree_distance_query_engine
// Loads tree edges, builds all-pairs distances by a stack walk, answers queries.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_distance_query_engine
  import tdq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [6:0]  cfg_data_i,      // node_count
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,    // node_a[5:0], node_b[11:6], edge_length[27:12]
  input  wire logic [1:0]  s_axis_tuser,    // mode[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,    // distance[21:0]
  output logic             m_axis_tuser     // reached[0]
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LD2   = 4'd2;
  localparam logic [3:0] S_QRD   = 4'd3;
  localparam logic [3:0] S_POP   = 4'd4;
  localparam logic [3:0] S_ROW   = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_WGT   = 4'd7;
  localparam logic [3:0] S_JRD   = 4'd8;
  localparam logic [3:0] S_JWR   = 4'd9;

  logic [3:0] state_q, state_d;

  // memories
  logic [MaxNodes-1:0] pres_mem [MaxNodes];
  logic [EdgeW-1:0]    wgt_mem  [MaxNodes*MaxNodes];
  logic [DistW-1:0]    dist_mem [MaxNodes*MaxNodes];
  node_t               stack_mem[MaxNodes];

  logic [MaxNodes-1:0] pres_rd_q;
  logic [EdgeW-1:0]    wgt_rd_q;
  logic [DistW-1:0]    dist_rd_q;
  node_t               stack_rd_q;

  count_t              node_count_q;
  count_t              n_use;
  logic [MaxNodes-1:0] n_mask;
  logic [MaxNodes-1:0] visited_q;
  count_t              depth_q;
  count_t              clr_q;
  count_t              j_q;
  node_t               v_q, u_q, a_q, b_q;
  logic [EdgeW-1:0]    len_q;
  logic [EdgeW-1:0]    w_q;
  logic                hit_q, reach_q;
  logic                out_valid_q;
  logic [DistW-1:0]    out_dist_q;
  logic                out_reach_q;

  node_t               in_a, in_b;
  logic [EdgeW-1:0]    in_len;
  logic [1:0]          in_mode;
  logic                accept;
  logic [MaxNodes-1:0] cand;
  logic                cand_any;
  node_t               cand_first;
  node_t               j_node;
  logic [DistW:0]      sum;
  logic [DistW-1:0]    sum_sat;
  logic                out_free;

  assign in_a    = s_axis_tdata[5:0];
  assign in_b    = s_axis_tdata[11:6];
  assign in_len  = s_axis_tdata[27:12];
  assign in_mode = s_axis_tuser;
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign j_node        = j_q[NodeW-1:0];

  always_comb begin
    if (node_count_q == '0) begin
      n_use = count_t'(1);
    end else if (node_count_q > count_t'(MaxNodes)) begin
      n_use = count_t'(MaxNodes);
    end else begin
      n_use = node_count_q;
    end
  end

  always_comb begin
    for (int i = 0; i < MaxNodes; i++) begin
      n_mask[i] = (count_t'(i) < n_use);
    end
  end

  // lowest unvisited neighbour of v
  assign cand     = pres_rd_q & ~visited_q & n_mask;
  assign cand_any = |cand;
  always_comb begin
    cand_first = '0;
    for (int i = MaxNodes - 1; i >= 0; i--) begin
      if (cand[i]) begin
        cand_first = node_t'(i);
      end
    end
  end

  // shared adder with saturation
  assign sum     = {1'b0, dist_rd_q} + (DistW+1)'(w_q);
  assign sum_sat = sum[DistW] ? DistMax : sum[DistW-1:0];

  // control flow
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == count_t'(MaxNodes - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          priority case (in_mode)
            MODE_LOAD:  if (in_a < n_use[NodeW-1:0] || n_use == count_t'(MaxNodes)) begin
                          state_d = S_LD2;
                        end
            MODE_BUILD: state_d = S_POP;
            MODE_QUERY: state_d = S_QRD;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_LD2:  state_d = S_IDLE;
      S_QRD:  if (out_free) state_d = S_IDLE;
      S_POP:  state_d = (depth_q == '0) ? S_IDLE : S_ROW;
      S_ROW:  state_d = S_SCAN;
      S_SCAN: state_d = cand_any ? S_WGT : S_POP;
      S_WGT:  state_d = S_JRD;
      S_JRD: begin
        if (j_q == n_use) begin
          state_d = S_POP;
        end else if (visited_q[j_node] && j_node != v_q) begin
          state_d = S_JWR;
        end
      end
      S_JWR:  state_d = S_JRD;
      default: state_d = S_IDLE;
    endcase
  end

  logic load_ok;
  assign load_ok = ({1'b0, in_a} < n_use) && ({1'b0, in_b} < n_use) && (in_a != in_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      node_count_q <= count_t'(MaxNodes);
      visited_q    <= '0;
      depth_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= (state_q == S_IDLE && accept && in_mode == MODE_LOAD && !load_ok)
                 ? S_IDLE : state_d;
      if (cfg_valid_i) node_count_q <= cfg_data_i;
      if (state_q == S_QRD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: clr_q <= clr_q + count_t'(1);
        S_IDLE: begin
          if (accept && in_mode == MODE_BUILD) begin
            visited_q <= {{(MaxNodes-1){1'b0}}, 1'b1};
            depth_q   <= count_t'(1);
          end
        end
        S_SCAN: if (!cand_any) depth_q <= depth_q - count_t'(1);
        S_JRD: begin
          if (j_q == n_use) begin
            visited_q[u_q] <= 1'b1;
            if (depth_q < count_t'(MaxNodes)) depth_q <= depth_q + count_t'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload and sequencing registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        a_q     <= in_a;
        b_q     <= in_b;
        len_q   <= in_len;
        hit_q   <= (in_a != in_b) && ({1'b0, in_a} < n_use) && ({1'b0, in_b} < n_use)
                   && visited_q[in_a] && visited_q[in_b];
        reach_q <= (in_a == in_b) && ({1'b0, in_a} < n_use);
      end
      S_QRD: begin
        if (out_free) begin
          out_dist_q  <= hit_q ? dist_rd_q : '0;
          out_reach_q <= hit_q || reach_q;
        end
      end
      S_ROW:  v_q <= stack_rd_q;
      S_SCAN: u_q <= cand_first;
      S_WGT: begin
        w_q <= wgt_rd_q;
        j_q <= '0;
      end
      S_JRD: begin
        if (j_q != n_use && !(visited_q[j_node] && j_node != v_q)) begin
          j_q <= j_q + count_t'(1);
        end
      end
      S_JWR:  j_q <= j_q + count_t'(1);
      default: ;
    endcase
  end

  // edge-present rows, cleared after reset
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      pres_mem[clr_q[NodeW-1:0]] <= '0;
    end else if (state_q == S_IDLE && accept && in_mode == MODE_LOAD && load_ok) begin
      pres_mem[in_a][in_b] <= 1'b1;
    end else if (state_q == S_LD2) begin
      pres_mem[b_q][a_q] <= 1'b1;
    end
    if (state_q == S_ROW) pres_rd_q <= pres_mem[stack_rd_q];
  end

  // edge weights
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && accept && in_mode == MODE_LOAD && load_ok) begin
      wgt_mem[{in_a, in_b}] <= in_len;
    end else if (state_q == S_LD2) begin
      wgt_mem[{b_q, a_q}] <= len_q;
    end
    if (state_q == S_SCAN) wgt_rd_q <= wgt_mem[{v_q, cand_first}];
  end

  // walk stack
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      stack_mem[0] <= '0;
    end else if (state_q == S_JRD && j_q == n_use && depth_q < count_t'(MaxNodes)) begin
      stack_mem[depth_q[NodeW-1:0]] <= u_q;
    end
    if (state_q == S_POP) stack_rd_q <= stack_mem[depth_q[NodeW-1:0] - node_t'(1)];
  end

  // distances, one entry per unordered pair
  always_ff @(posedge clk_i) begin
    if (state_q == S_JWR) begin
      dist_mem[pair_cell(j_node, u_q)] <= sum_sat;
    end else if (state_q == S_JRD && j_q == n_use) begin
      dist_mem[pair_cell(v_q, u_q)] <= DistW'(w_q);
    end
    if (state_q == S_IDLE) begin
      dist_rd_q <= dist_mem[pair_cell(in_a, in_b)];
    end else if (state_q == S_JRD) begin
      dist_rd_q <= dist_mem[pair_cell(j_node, v_q)];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_dist_q};
  assign m_axis_tuser  = out_reach_q;

`ifndef ASSERT_OFF
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= count_t'(MaxNodes))
    else $error("walk stack depth out of range");

  a_root_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROW || state_q == S_SCAN || state_q == S_JRD) |-> visited_q[0])
    else $error("root not marked during walk");

  a_j_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_JRD || state_q == S_JWR) |-> j_q <= n_use)
    else $error("pair counter past node count");

  a_new_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WGT) |-> !visited_q[u_q])
    else $error("walk picked a visited node");
`endif

endmodule

`default_nettype wire

// ----- dv/tree_distance_query_engine_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tree_distance_query_engine_tb
// Loads random trees, builds distances and checks every query against a
// model of the walk kept in the bench, under random input gaps and output
// stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_distance_query_engine_tb;
  import tdq_pkg::*;

  localparam int unsigned StallLimit = 200000;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             reached;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  tree_distance_query_engine i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [EdgeW-1:0] edge_len   [MaxNodes][MaxNodes];
  logic             edge_on    [MaxNodes][MaxNodes];
  logic [DistW-1:0] path_len   [MaxNodes][MaxNodes];
  logic             path_known [MaxNodes][MaxNodes];
  int unsigned      nodes_cfg = 64;
  answer_t          answer_q[$];

  int  fail_cnt = 0;
  int  idle_cycles = 0;
  int  burst_left = 0;
  bit  hold_off = 1'b0;
  bit  stall_free = 1'b0;

  function automatic int unsigned active_nodes();
    if (nodes_cfg < 1) return 1;
    if (nodes_cfg > MaxNodes) return MaxNodes;
    return nodes_cfg;
  endfunction

  function automatic void record_path(int a, int b, logic [DistW-1:0] d);
    path_len[a][b] = d;
    path_len[b][a] = d;
    path_known[a][b] = 1'b1;
    path_known[b][a] = 1'b1;
  endfunction

  function automatic void walk_tree();
    int unsigned n;
    bit          seen[MaxNodes];
    int          stack[$];
    int          v, u;
    logic [EdgeW-1:0] w;
    longint      d;
    n = active_nodes();
    foreach (seen[i]) seen[i] = 1'b0;
    foreach (path_known[i, j]) path_known[i][j] = 1'b0;
    seen[0] = 1'b1;
    stack = {stack, 0};
    while (stack.size() > 0) begin
      v = stack[$];
      u = -1;
      for (int k = 0; k < n; k++) begin
        if (edge_on[v][k] && !seen[k]) begin
          u = k;
          break;
        end
      end
      if (u < 0) begin
        void'(stack.pop_back());
        continue;
      end
      w = edge_len[v][u];
      for (int j = 0; j < n; j++) begin
        if (j != v && seen[j] && path_known[j][v]) begin
          d = longint'(path_len[j][v]) + longint'(w);
          if (d > DistMax) d = DistMax;
          record_path(j, u, DistW'(d));
        end
      end
      record_path(v, u, DistW'(w));
      seen[u] = 1'b1;
      stack = {stack, u};
    end
  endfunction

  function automatic void predict(logic [1:0] mode, int a, int b, logic [EdgeW-1:0] len);
    int unsigned n;
    answer_t     ans;
    n = active_nodes();
    case (mode)
      MODE_LOAD: begin
        if (a < n && b < n && a != b) begin
          edge_len[a][b] = len;
          edge_len[b][a] = len;
          edge_on[a][b] = 1'b1;
          edge_on[b][a] = 1'b1;
        end
      end
      MODE_BUILD: walk_tree();
      MODE_QUERY: begin
        ans = '0;
        if (a == b) begin
          ans.reached = (a < n);
        end else if (a < n && b < n && path_known[a][b]) begin
          ans.distance = path_len[a][b];
          ans.reached = 1'b1;
        end
        answer_q = {answer_q, ans};
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(logic [1:0] mode, int a, int b, logic [EdgeW-1:0] len);
    int gap;
    // random bursts and gaps on the input side
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {4'd0, len, 6'(b), 6'(a)};
    do @(posedge clk_i); while (!s_axis_tready);
    predict(mode, a, b, len);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    // loads and builds give no answer; wait until the block is idle
    do begin
      @(posedge clk_i);
      guard++;
    end while ((answer_q.size() > 0 || !s_axis_tready || m_axis_tvalid) &&
               guard < StallLimit);
  endtask

  task automatic write_node_count(int unsigned value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= 7'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    nodes_cfg = value & 7'h7f;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_random_tree(int unsigned n, bit long_edges);
    for (int k = 1; k < n; k++) begin
      send_request(MODE_LOAD, k, $urandom_range(0, k - 1),
                   long_edges ? 16'hffff - 16'($urandom_range(0, 3)) : 16'($urandom));
    end
  endtask

  task automatic test_directed();
    write_node_count(4);
    send_request(MODE_LOAD, 0, 1, 16'hffff);
    send_request(MODE_LOAD, 1, 2, 16'h0000);
    send_request(MODE_LOAD, 2, 2, 16'h1234);   // equal endpoints, dropped
    send_request(MODE_LOAD, 3, 63, 16'h5555);  // out of range, dropped
    send_request(2'd3, 63, 63, 16'hffff);      // unused mode, dropped
    send_request(MODE_QUERY, 0, 1, 16'h0);     // nothing built yet
    send_request(MODE_BUILD, 0, 0, 16'h0);
    send_request(MODE_QUERY, 0, 2, 16'h0);
    send_request(MODE_QUERY, 2, 1, 16'h0);
    send_request(MODE_QUERY, 0, 3, 16'h0);     // unreached node
    send_request(MODE_QUERY, 3, 3, 16'h0);
    send_request(MODE_QUERY, 63, 63, 16'h0);   // equal but out of range
    send_request(MODE_QUERY, 0, 63, 16'h0);
    send_request(MODE_LOAD, 1, 0, 16'h0001);   // overwrite a length
    send_request(MODE_LOAD, 2, 3, 16'haaaa);
    send_request(MODE_BUILD, 0, 0, 16'h0);
    send_request(MODE_QUERY, 3, 0, 16'h0);
    send_request(MODE_QUERY, 1, 3, 16'h0);
    write_node_count(1);
    send_request(MODE_BUILD, 0, 0, 16'h0);
    send_request(MODE_QUERY, 0, 0, 16'h0);
    send_request(MODE_QUERY, 0, 1, 16'h0);
  endtask

  task automatic test_saturation();
    // long chain of maximal edges drives sums near the top of the distance width without passing it
    write_node_count(64);
    for (int k = 1; k < 64; k++) send_request(MODE_LOAD, k - 1, k, 16'hffff);
    send_request(MODE_BUILD, 0, 0, 16'h0);
    send_request(MODE_QUERY, 0, 63, 16'h0);
    send_request(MODE_QUERY, 63, 0, 16'h0);
    send_request(MODE_QUERY, 10, 60, 16'h0);
  endtask

  task automatic test_random_trees();
    int unsigned n;
    for (int t = 0; t < 40; t++) begin
      n = (t % 9 == 0) ? 64 : $urandom_range(2, 12);
      write_node_count(t == 20 ? 0 : (t == 21 ? 127 : n));
      n = active_nodes();
      load_random_tree(n, t % 7 == 3);
      if ($urandom_range(0, 3) == 0)
        send_request(MODE_LOAD, $urandom_range(0, 63), $urandom_range(0, 63), 16'($urandom));
      send_request(MODE_BUILD, 0, 0, 16'($urandom));
      for (int q = 0; q < 10; q++) begin
        if ($urandom_range(0, 9) == 0)
          send_request(2'($urandom_range(0, 3)), $urandom_range(0, 63),
                       $urandom_range(0, 63), 16'($urandom));
        else
          send_request(MODE_QUERY, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                       16'($urandom));
      end
    end
  endtask

  task automatic test_back_pressure();
    write_node_count(8);
    load_random_tree(8, 1'b0);
    send_request(MODE_BUILD, 0, 0, 16'h0);
    hold_off = 1'b1;
    for (int q = 0; q < 40; q++)
      send_request(MODE_QUERY, $urandom_range(0, 7), $urandom_range(0, 7), 16'h0);
    stall_free = 1'b1;
    for (int q = 0; q < 40; q++)
      send_request(MODE_QUERY, $urandom_range(0, 7), $urandom_range(0, 7), 16'h0);
    stall_free = 1'b0;
  endtask

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int hold_cnt;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < 300; hold_cnt++) @(posedge clk_i);
        hold_off = 1'b0;
      end
      m_axis_tready <= stall_free ? 1'b1 : ($urandom_range(0, 9) > 2);
    end
  end

  // answer checker and watchdog
  always @(posedge clk_i) begin
    answer_t want;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (answer_q.size() == 0) begin
        $error("unexpected answer distance=%0d reached=%0b", m_axis_tdata[21:0], m_axis_tuser);
        fail_cnt++;
      end else begin
        want = answer_q.pop_front();
        if (m_axis_tdata[21:0] !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, m_axis_tdata[21:0]);
          fail_cnt++;
        end
        if (m_axis_tuser !== want.reached) begin
          $error("reached: expected %0b, got %0b", want.reached, m_axis_tuser);
          fail_cnt++;
        end
      end
    end
    if (idle_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    foreach (edge_on[i, j]) begin
      edge_on[i][j] = 1'b0;
      path_known[i][j] = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_saturation();
    test_random_trees();
    test_back_pressure();
    drain();
    if (answer_q.size() != 0) begin
      $error("answers never arrived: %0d", answer_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- tree_distance_query_engine.f -----
sv/tdq_pkg.sv
sv/tree_distance_query_engine.sv
dv/tree_distance_query_engine_tb.sv
